@@ hdl/mlrq_pkg.sv @@
// shared constants and types for the multilevel linked run queue
// field widths, action and status codes, controller state type
// no dependencies
package mlrq_pkg;

  localparam int NUM_LEVELS_DEF = 8;
  localparam int NUM_TASKS_DEF  = 64;

  localparam int ACTION_W = 2;
  localparam int LEVEL_W  = 3;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_NULL,
    ST_ENQ_LINK,
    ST_DEQ,
    ST_WALK,
    ST_REM_CLR,
    ST_FIN
  } state_t;

endpackage

@@ hdl/multilevel_linked_run_queue_core.sv @@
// top level of the multilevel linked run queue
// uses mlrq_pkg and mlrq_ram (next-pointer store)

// One FIFO of task ids per priority level, kept as linked lists: head and tail
// pointers per level in flip-flops, one next pointer per task id in a ram with
// one write and one registered read port. A transaction is taken when start is
// high and busy low; the result appears on the out_ ports for exactly one cycle
// with out_valid high and must be taken then, as nothing can hold it off. Busy
// falls in the cycle the result is shown, so a new start can be taken then.
// An enqueue writes a null next pointer for the id and then, when the level's
// tail is not null, links the id behind that tail. A dequeue of an empty level
// goes straight to the result. A remove walks the level's list, visiting at most
// NUM_TASKS entries, and clears the found id's link. The walk is bound by the ram
// read port, one link per cycle. No clearing pass is needed after reset.
module multilevel_linked_run_queue_core
  import mlrq_pkg::*;
#(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int NUM_TASKS  = NUM_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mlrq_pkg::ACTION_W-1:0]  in_action,
  input  logic [mlrq_pkg::LEVEL_W-1:0]   in_level,
  input  logic [mlrq_pkg::ID_W-1:0]      in_task_id,
  output logic                           out_valid,
  output logic [mlrq_pkg::STATUS_W-1:0]  out_status,
  output logic [mlrq_pkg::ID_W-1:0]      out_popped_id,
  output logic                           out_any_ready,
  output logic [mlrq_pkg::LEVEL_W-1:0]   out_first_level
);

  localparam int PTR_W = $clog2(NUM_TASKS + 1);
  localparam int AW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(NUM_TASKS);
  localparam logic [PTR_W-1:0] LAST_STEP = PTR_W'(NUM_TASKS - 1);

  function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
    return p < NULL_PTR;
  endfunction

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]    head_r [NUM_LEVELS];
  logic [PTR_W-1:0]    head_nxt [NUM_LEVELS];
  logic [PTR_W-1:0]    tail_r [NUM_LEVELS];
  logic [PTR_W-1:0]    tail_nxt [NUM_LEVELS];

  logic [LW-1:0]       lidx_r, lidx_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [PTR_W-1:0]    cur_r, cur_nxt;
  logic [PTR_W-1:0]    prev_r, prev_nxt;
  logic [PTR_W-1:0]    steps_r, steps_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]     popped_r, popped_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_popped_r, out_popped_nxt;
  logic                out_any_r, out_any_nxt;
  logic [LEVEL_W-1:0]  out_first_r, out_first_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [PTR_W-1:0]    ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [PTR_W-1:0]    ram_rdata;

  logic                accept;
  logic                in_lvl_ok;
  logic                in_id_ok;
  logic [LW-1:0]       in_lidx;
  logic [PTR_W-1:0]    in_head;
  logic                walk_hit;
  logic                walk_end;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_lvl_ok = (32'(in_level) < NUM_LEVELS);
  assign in_id_ok  = (32'(in_task_id) < NUM_TASKS);
  assign in_lidx   = LW'(in_level);
  assign in_head   = in_lvl_ok ? head_r[in_lidx] : NULL_PTR;
  // ids reaching the walk are below NUM_TASKS, so the cast keeps them intact
  assign walk_hit  = (cur_r == PTR_W'(id_r));
  assign walk_end  = !ptr_ok(ram_rdata) || (steps_r == LAST_STEP);

  mlrq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_TASKS),
    .AW    (AW)
  ) u_next_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_ENQUEUE: state_nxt = (in_lvl_ok && in_id_ok) ? ST_ENQ_NULL : ST_FIN;
            ACT_DEQUEUE: state_nxt = ptr_ok(in_head) ? ST_DEQ : ST_FIN;
            ACT_REMOVE:  state_nxt = (in_id_ok && ptr_ok(in_head)) ? ST_WALK : ST_FIN;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_ENQ_NULL: state_nxt = ptr_ok(tail_r[lidx_r]) ? ST_ENQ_LINK : ST_FIN;
      ST_ENQ_LINK: state_nxt = ST_FIN;
      ST_DEQ:      state_nxt = ST_FIN;
      ST_WALK: begin
        if (walk_hit) begin
          state_nxt = ST_REM_CLR;
        end else if (walk_end) begin
          state_nxt = ST_FIN;
        end
      end
      ST_REM_CLR:  state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    lidx_nxt       = lidx_r;
    id_nxt         = id_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    steps_nxt      = steps_r;
    status_nxt     = status_r;
    popped_nxt     = popped_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_popped_nxt = out_popped_r;
    out_any_nxt    = out_any_r;
    out_first_nxt  = out_first_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(id_r);
    ram_wdata      = NULL_PTR;
    ram_raddr      = AW'(cur_r);

    case (state_r)
      ST_IDLE: begin
        ram_raddr = AW'(in_head);
        if (accept) begin
          lidx_nxt   = in_lidx;
          id_nxt     = in_task_id;
          cur_nxt    = in_head;
          prev_nxt   = NULL_PTR;
          steps_nxt  = '0;
          popped_nxt = '0;
          status_nxt = STAT_OK;
          case (in_action)
            ACT_DEQUEUE: begin
              if (!ptr_ok(in_head)) status_nxt = STAT_EMPTY;
            end
            ACT_REMOVE: begin
              if (!(in_id_ok && ptr_ok(in_head))) status_nxt = STAT_NOT_FOUND;
            end
            default: ;
          endcase
        end
      end
      ST_ENQ_NULL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(id_r);
        ram_wdata = NULL_PTR;
        if (!ptr_ok(tail_r[lidx_r])) begin
          head_nxt[lidx_r] = PTR_W'(id_r);
          tail_nxt[lidx_r] = PTR_W'(id_r);
        end
      end
      ST_ENQ_LINK: begin
        ram_we           = 1'b1;
        ram_waddr        = AW'(tail_r[lidx_r]);
        ram_wdata        = PTR_W'(id_r);
        tail_nxt[lidx_r] = PTR_W'(id_r);
      end
      ST_DEQ: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(cur_r);
        ram_wdata  = NULL_PTR;
        popped_nxt = ID_W'(cur_r);
        if (ptr_ok(ram_rdata)) begin
          head_nxt[lidx_r] = ram_rdata;
        end else begin
          head_nxt[lidx_r] = NULL_PTR;
          tail_nxt[lidx_r] = NULL_PTR;
        end
      end
      ST_WALK: begin
        if (walk_hit) begin
          // unlink: predecessor or head takes the successor
          if (ptr_ok(prev_r)) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(prev_r);
            ram_wdata = ram_rdata;
          end else begin
            head_nxt[lidx_r] = ram_rdata;
          end
          if (tail_r[lidx_r] == cur_r) tail_nxt[lidx_r] = prev_r;
        end else begin
          // follow the link just read and fetch the one after it
          prev_nxt  = cur_r;
          cur_nxt   = ram_rdata;
          steps_nxt = steps_r + PTR_W'(1);
          ram_raddr = AW'(ram_rdata);
          if (walk_end) status_nxt = STAT_NOT_FOUND;
        end
      end
      ST_REM_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur_r);
        ram_wdata = NULL_PTR;
        if (!ptr_ok(head_r[lidx_r])) begin
          head_nxt[lidx_r] = NULL_PTR;
          tail_nxt[lidx_r] = NULL_PTR;
        end
      end
      ST_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_popped_nxt = popped_r;
        out_any_nxt    = 1'b0;
        out_first_nxt  = '0;
        // priority pick of the lowest non-empty level
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
          if (ptr_ok(head_r[i]) && ptr_ok(tail_r[i])) begin
            out_any_nxt   = 1'b1;
            out_first_nxt = LEVEL_W'(i);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= NULL_PTR;
        tail_r[i] <= NULL_PTR;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lidx_r       <= lidx_nxt;
    id_r         <= id_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    status_r     <= status_nxt;
    popped_r     <= popped_nxt;
    out_status_r <= out_status_nxt;
    out_popped_r <= out_popped_nxt;
    out_any_r    <= out_any_nxt;
    out_first_r  <= out_first_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_popped_id   = out_popped_r;
  assign out_any_ready   = out_any_r;
  assign out_first_level = out_first_r;

endmodule

@@ hdl/mlrq_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mlrq_checker.sv @@
// port-level checks for the multilevel linked run queue, bound to the top level
// uses mlrq_pkg status codes
module mlrq_checker
  import mlrq_pkg::*;
(
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [mlrq_pkg::ACTION_W-1:0]  in_action,
  input logic [mlrq_pkg::LEVEL_W-1:0]   in_level,
  input logic [mlrq_pkg::ID_W-1:0]      in_task_id,
  input logic                           out_valid,
  input logic [mlrq_pkg::STATUS_W-1:0]  out_status,
  input logic [mlrq_pkg::ID_W-1:0]      out_popped_id,
  input logic                           out_any_ready,
  input logic [mlrq_pkg::LEVEL_W-1:0]   out_first_level
);

  // a taken transaction keeps the block busy until its result
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a transaction was taken");

  // one result strobe per transaction, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in flight");

  a_popped_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_popped_id == '0))
    else $error("popped id set on a failed action");

  a_first_level_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_ready |-> (out_first_level == '0))
    else $error("first level set while no level is ready");

endmodule

bind multilevel_linked_run_queue_core mlrq_checker u_mlrq_checker (.*);
